### design/double_ended_queue_core_assert.svh
// assertion macros for the double-ended queue control module
`ifndef DOUBLE_ENDED_QUEUE_CORE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_CORE_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define DEQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define DEQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/deq_pkg.sv
// types and constants for the double-ended queue
package deq_pkg;

    localparam int VALUE_W = 32;

    // word reported as front value while the queue is empty
    localparam logic [VALUE_W-1:0] EMPTY_FRONT = {VALUE_W{1'b1}};

    typedef enum logic [1:0] {
        MODE_PUSH_FRONT = 2'd0,
        MODE_PUSH_REAR  = 2'd1,
        MODE_POP_FRONT  = 2'd2,
        MODE_POP_REAR   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        STATUS_DONE      = 2'd0,
        STATUS_OVERFLOW  = 2'd1,
        STATUS_UNDERFLOW = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_READ = 1'b1
    } t_state;

endpackage

### design/deq_ram.sv
// generic single-write, single-read ram with registered read data
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered read data
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/deq_ctrl.sv
// pointer, count and front-word control for the double-ended queue
`include "double_ended_queue_core_assert.svh"

module deq_ctrl #(
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH),
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // input item
    input  logic                         i_valid,
    output logic                         o_ready,
    input  deq_pkg::t_mode               i_mode,
    input  logic [deq_pkg::VALUE_W-1:0]  i_value,
    // result item
    output logic                         o_valid,
    input  logic                         i_ready,
    output deq_pkg::t_status             o_status,
    output logic [deq_pkg::VALUE_W-1:0]  o_front,
    output logic [CW-1:0]                o_count,
    // slot memory
    output logic                         o_we,
    output logic [AW-1:0]                o_waddr,
    output logic [deq_pkg::VALUE_W-1:0]  o_wdata,
    output logic                         o_re,
    output logic [AW-1:0]                o_raddr,
    input  logic [deq_pkg::VALUE_W-1:0]  i_rdata
);

    deq_pkg::t_state r_state, n_state;

    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_count, n_count;
    logic [deq_pkg::VALUE_W-1:0] r_front, n_front;

    logic r_out_valid, n_out_valid;
    deq_pkg::t_status r_out_status, n_out_status;
    logic [deq_pkg::VALUE_W-1:0] r_out_front, n_out_front;
    logic [CW-1:0] r_out_count, n_out_count;

    logic accept;
    logic empty;
    logic full;
    logic [AW-1:0] head_next, head_prev, tail_next, tail_prev;

    // handshake and queue conditions
    assign o_ready = (r_state == deq_pkg::S_IDLE) && (!r_out_valid || i_ready);
    assign accept  = i_valid && o_ready;
    assign empty   = (r_count == '0);
    assign full    = (r_count == CW'(DEPTH));

    // circular pointer neighbors
    assign head_next = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + AW'(1);
    assign head_prev = (r_head == '0) ? AW'(DEPTH - 1) : r_head - AW'(1);
    assign tail_next = (r_tail == AW'(DEPTH - 1)) ? '0 : r_tail + AW'(1);
    assign tail_prev = (r_tail == '0) ? AW'(DEPTH - 1) : r_tail - AW'(1);

    // next state: a pop at the front that leaves words behind reads the new front
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            deq_pkg::S_IDLE: begin
                if (accept && i_mode == deq_pkg::MODE_POP_FRONT && r_count > CW'(1)) begin
                    n_state = deq_pkg::S_READ;
                end
            end
            deq_pkg::S_READ: begin
                n_state = deq_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and memory requests
    always_comb begin
        n_head       = r_head;
        n_tail       = r_tail;
        n_count      = r_count;
        n_front      = r_front;
        n_out_valid  = r_out_valid && !i_ready;
        n_out_status = r_out_status;
        n_out_front  = r_out_front;
        n_out_count  = r_out_count;
        o_we         = 1'b0;
        o_waddr      = r_tail;
        o_wdata      = i_value;
        o_re         = 1'b0;
        o_raddr      = head_next;
        unique case (r_state)
            deq_pkg::S_IDLE: begin
                if (accept) begin
                    n_out_valid  = 1'b1;
                    n_out_status = deq_pkg::STATUS_DONE;
                    n_out_front  = empty ? deq_pkg::EMPTY_FRONT : r_front;
                    n_out_count  = r_count;
                    unique case (i_mode)
                        deq_pkg::MODE_PUSH_FRONT: begin
                            if (full) begin
                                n_out_status = deq_pkg::STATUS_OVERFLOW;
                            end else begin
                                o_we        = 1'b1;
                                o_waddr     = head_prev;
                                n_head      = head_prev;
                                n_count     = r_count + CW'(1);
                                n_front     = i_value;
                                n_out_front = i_value;
                                n_out_count = r_count + CW'(1);
                            end
                        end
                        deq_pkg::MODE_PUSH_REAR: begin
                            if (full) begin
                                n_out_status = deq_pkg::STATUS_OVERFLOW;
                            end else begin
                                o_we        = 1'b1;
                                o_waddr     = r_tail;
                                n_tail      = tail_next;
                                n_count     = r_count + CW'(1);
                                n_out_count = r_count + CW'(1);
                                // first word in an empty queue becomes the front
                                if (empty) begin
                                    n_front     = i_value;
                                    n_out_front = i_value;
                                end
                            end
                        end
                        deq_pkg::MODE_POP_FRONT: begin
                            if (empty) begin
                                n_out_status = deq_pkg::STATUS_UNDERFLOW;
                            end else begin
                                n_head      = head_next;
                                n_count     = r_count - CW'(1);
                                n_out_count = r_count - CW'(1);
                                if (r_count == CW'(1)) begin
                                    n_out_front = deq_pkg::EMPTY_FRONT;
                                end else begin
                                    // result waits for the new front word
                                    o_re        = 1'b1;
                                    n_out_valid = 1'b0;
                                end
                            end
                        end
                        deq_pkg::MODE_POP_REAR: begin
                            if (empty) begin
                                n_out_status = deq_pkg::STATUS_UNDERFLOW;
                            end else begin
                                n_tail      = tail_prev;
                                n_count     = r_count - CW'(1);
                                n_out_count = r_count - CW'(1);
                                if (r_count == CW'(1)) begin
                                    n_out_front = deq_pkg::EMPTY_FRONT;
                                end
                            end
                        end
                    endcase
                end
            end
            deq_pkg::S_READ: begin
                // new front word arrives from the memory
                n_front      = i_rdata;
                n_out_valid  = 1'b1;
                n_out_status = deq_pkg::STATUS_DONE;
                n_out_front  = i_rdata;
                n_out_count  = r_count;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= deq_pkg::S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_front      <= n_front;
        r_out_status <= n_out_status;
        r_out_front  <= n_out_front;
        r_out_count  <= n_out_count;
    end

    assign o_valid  = r_out_valid;
    assign o_status = r_out_status;
    assign o_front  = r_out_front;
    assign o_count  = r_out_count;

    // checks on pointer and sequencing consistency
    `DEQ_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(DEPTH), "count above depth")
    `DEQ_ASSERT_NOW(a_ptr_meet, i_clk, i_rst_n, r_count == '0 || r_count == CW'(DEPTH), r_head == r_tail, "pointers apart when empty or full")
    `DEQ_ASSERT_NOW(a_read_out_free, i_clk, i_rst_n, r_state == deq_pkg::S_READ, !r_out_valid && !o_ready, "read cycle with busy output or open input")
    `DEQ_ASSERT_NEXT(a_pop_read, i_clk, i_rst_n, accept && i_mode == deq_pkg::MODE_POP_FRONT && r_count > CW'(1), r_state == deq_pkg::S_READ && r_count == $past(r_count) - CW'(1), "front pop without refill read")

endmodule

### design/double_ended_queue_core.sv
// an accepted item's result is held in the output register; a front pop leaving words
// behind first fetches the new front word through the slot memory's registered read port
// throughput: one item per cycle while results are taken; input waits out such a pop's read
// the output register frees the input while a result waits, as long as it is taken
// reset (synchronous, active low) empties the queue; slot contents are kept undefined
module double_ended_queue_core #(
    parameter int DEPTH = 16,
    localparam int CW = $clog2(DEPTH + 1),
    localparam int TDATA_W = ((deq_pkg::VALUE_W + CW + 7) / 8) * 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // fields from lsb: value
    input  logic [deq_pkg::VALUE_W-1:0] i_s_axis_tdata,
    // fields from lsb: mode
    input  logic [1:0]                  i_s_axis_tuser,
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // fields from lsb: front_value, occupancy, zero fill
    output logic [TDATA_W-1:0]          o_m_axis_tdata,
    // fields from lsb: status
    output logic [1:0]                  o_m_axis_tuser,
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready
);

    localparam int AW = $clog2(DEPTH);

    logic                        mem_we;
    logic [AW-1:0]               mem_waddr;
    logic [deq_pkg::VALUE_W-1:0] mem_wdata;
    logic                        mem_re;
    logic [AW-1:0]               mem_raddr;
    logic [deq_pkg::VALUE_W-1:0] mem_rdata;
    deq_pkg::t_status            out_status;
    logic [deq_pkg::VALUE_W-1:0] out_front;
    logic [CW-1:0]               out_count;

    // queue control
    deq_ctrl #(
        .DEPTH(DEPTH)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_axis_tvalid),
        .o_ready  (o_s_axis_tready),
        .i_mode   (deq_pkg::t_mode'(i_s_axis_tuser)),
        .i_value  (i_s_axis_tdata),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_status (out_status),
        .o_front  (out_front),
        .o_count  (out_count),
        .o_we     (mem_we),
        .o_waddr  (mem_waddr),
        .o_wdata  (mem_wdata),
        .o_re     (mem_re),
        .o_raddr  (mem_raddr),
        .i_rdata  (mem_rdata)
    );

    // slot storage
    deq_ram #(
        .WIDTH(deq_pkg::VALUE_W),
        .DEPTH(DEPTH)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // result packing
    assign o_m_axis_tdata = TDATA_W'({out_count, out_front});
    assign o_m_axis_tuser = out_status;

endmodule
